>>> hw/rtl/rt_lpm_pkg.sv
// ----------------------------------------------------------------------------
// rt_lpm_pkg
// Shared types, codes and helpers for the route table with longest prefix match.
// ----------------------------------------------------------------------------
package rt_lpm_pkg;

  // request codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_MASK = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_MISS     = 2'd3
  } stat_t;

  // ports at or above this count are rejected on insert
  localparam int PORT_COUNT = 16;

  // one route as held in a cell, with its prefix length kept alongside
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [3:0]  port;
    logic [5:0]  len;
  } entry_t;

  // running search word handed from cell to cell
  typedef struct packed {
    logic       vld;
    logic       found;
    logic       hit;
    logic [5:0] plen;
    logic [3:0] oport;
  } acc_t;

  // table update issued when the search word leaves the chain
  typedef struct packed {
    logic wr;
    logic shift;
  } upd_t;

  // number of ones in a 32-bit mask, summed a nibble at a time
  function automatic logic [5:0] ones_in(input logic [31:0] m);
    logic [5:0] n;
    logic [3:0] nib;
    n = 6'd0;
    for (int k = 0; k < 8; k++) begin
      nib = m[4*k +: 4];
      n = n + 6'(nib[0]) + 6'(nib[1]) + 6'(nib[2]) + 6'(nib[3]);
    end
    return n;
  endfunction

  // leading ones followed only by zeros
  function automatic logic mask_ok(input logic [31:0] m);
    logic [31:0] inv;
    inv = ~m;
    return ((inv & (inv + 32'd1)) == 32'd0);
  endfunction

endpackage

>>> hw/rtl/route_table_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// route_table_longest_prefix_match
// Ordered IPv4 route table with insert, delete, longest prefix lookup and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The request word then
// walks down a chain of TABLE_DEPTH cells, one cell per cycle, each cell
// holding one route; at the end of the chain the table is updated and the
// result shows on the out_ ports for one cycle with out_valid high. The result
// appears in the same cycle that busy drops, and a new request is taken only
// once the last one is through. The receiver cannot hold results off and must
// take each one when out_valid is high. Deletes close the gap so later routes
// keep their order; on a lookup an equal-length tie goes to the earlier route.
module route_table_longest_prefix_match #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_address,
  input  logic [31:0] in_netmask,
  input  logic [31:0] in_gateway,
  input  logic [3:0]  in_port,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [3:0]  out_port,
  output logic [5:0]  out_prefix_length,
  output logic [4:0]  out_entry_total
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  rt_lpm_pkg::entry_t  req_r;
  rt_lpm_pkg::act_t    act_r;
  rt_lpm_pkg::acc_t    launch_r, launch_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  rt_lpm_pkg::upd_t    upd;
  logic                accept, done, bad_route;

  rt_lpm_pkg::acc_t    acc   [TABLE_DEPTH+1];
  logic [IdxW-1:0]     idx   [TABLE_DEPTH+1];
  rt_lpm_pkg::entry_t  ent   [TABLE_DEPTH];

  logic                out_valid_r;
  logic [1:0]          out_status_r, status_nxt;
  logic                out_hit_r;
  logic [3:0]          out_port_r;
  logic [5:0]          out_plen_r;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_WALK);
  assign done   = (state_r == S_WALK) && acc[TABLE_DEPTH].vld;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= rt_lpm_pkg::act_t'(in_action);
      req_r.dest <= in_address;
      req_r.mask <= in_netmask;
      req_r.gw   <= in_gateway;
      req_r.port <= in_port;
      req_r.len  <= rt_lpm_pkg::ones_in(in_netmask);
    end
  end

  // launch word for the first cell
  always_comb begin
    launch_nxt     = '0;
    launch_nxt.vld = accept;
  end

  assign acc[0] = launch_r;
  assign idx[0] = '0;

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rt_lpm_pkg::entry_t nbr;
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign nbr = ent[i+1];
    end else begin : g_last
      assign nbr = ent[i];
    end
    rt_lpm_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (i),
      .CntW        (CntW),
      .IdxW        (IdxW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .cnt     (cnt_r),
      .upd     (upd),
      .del_idx (idx[TABLE_DEPTH]),
      .nbr     (nbr),
      .acc_in  (acc[i]),
      .idx_in  (idx[i]),
      .acc_out (acc[i+1]),
      .idx_out (idx[i+1]),
      .ent     (ent[i])
    );
  end

  assign bad_route = !rt_lpm_pkg::mask_ok(req_r.mask) ||
                     ({5'd0, req_r.port} >= 9'(rt_lpm_pkg::PORT_COUNT));

  // table update and status once the word leaves the chain
  always_comb begin
    upd        = '0;
    cnt_nxt    = cnt_r;
    status_nxt = rt_lpm_pkg::STAT_OK;
    if (done) begin
      unique case (act_r)
        rt_lpm_pkg::ACT_INSERT: begin
          priority if (bad_route) begin
            status_nxt = rt_lpm_pkg::STAT_BAD_MASK;
          end else if (acc[TABLE_DEPTH].found) begin
            status_nxt = rt_lpm_pkg::STAT_OK;
          end else if (cnt_r >= CntW'(TABLE_DEPTH)) begin
            status_nxt = rt_lpm_pkg::STAT_FULL;
          end else begin
            upd.wr  = 1'b1;
            cnt_nxt = cnt_r + CntW'(1);
          end
        end
        rt_lpm_pkg::ACT_DELETE: begin
          if (acc[TABLE_DEPTH].found) begin
            upd.shift = 1'b1;
            cnt_nxt   = cnt_r - CntW'(1);
          end else begin
            status_nxt = rt_lpm_pkg::STAT_MISS;
          end
        end
        rt_lpm_pkg::ACT_LOOKUP: begin
          if (!acc[TABLE_DEPTH].hit) begin
            status_nxt = rt_lpm_pkg::STAT_MISS;
          end
        end
        rt_lpm_pkg::ACT_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_WALK;
      S_WALK: if (done)   state_nxt = S_IDLE;
      default:            state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= done;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= status_nxt;
      if (act_r == rt_lpm_pkg::ACT_LOOKUP) begin
        out_hit_r  <= acc[TABLE_DEPTH].hit;
        out_port_r <= acc[TABLE_DEPTH].oport;
        out_plen_r <= acc[TABLE_DEPTH].plen;
      end else begin
        out_hit_r  <= 1'b0;
        out_port_r <= 4'd0;
        out_plen_r <= 6'd0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_hit           = out_hit_r;
  assign out_port          = out_port_r;
  assign out_prefix_length = out_plen_r;
  assign out_entry_total   = 5'(cnt_r);

endmodule

>>> hw/rtl/rt_lpm_cell.sv
// ----------------------------------------------------------------------------
// rt_lpm_cell
// One table slot: holds a route, checks the passing search word against it
// and registers the word before handing it on to the next slot.
// ----------------------------------------------------------------------------
module rt_lpm_cell #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX         = 0,
  parameter int CntW        = $clog2(TABLE_DEPTH + 1),
  parameter int IdxW        = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rt_lpm_pkg::entry_t  req,
  input  logic [CntW-1:0]     cnt,
  input  rt_lpm_pkg::upd_t    upd,
  input  logic [IdxW-1:0]     del_idx,
  input  rt_lpm_pkg::entry_t  nbr,
  input  rt_lpm_pkg::acc_t    acc_in,
  input  logic [IdxW-1:0]     idx_in,
  output rt_lpm_pkg::acc_t    acc_out,
  output logic [IdxW-1:0]     idx_out,
  output rt_lpm_pkg::entry_t  ent
);

  rt_lpm_pkg::entry_t ent_r;
  rt_lpm_pkg::acc_t   acc_r, acc_nxt;
  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic               active, ident, match;

  // slot holds a live route
  assign active = (CntW'(IDX) < cnt);

  assign ident = active && (ent_r.dest == req.dest) && (ent_r.mask == req.mask) &&
                 (ent_r.gw == req.gw) && (ent_r.port == req.port);

  assign match = active && (((ent_r.dest ^ req.dest) & ent_r.mask) == 32'd0);

  // update the search word with this slot
  always_comb begin
    acc_nxt = acc_in;
    idx_nxt = idx_in;
    if (acc_in.vld) begin
      if (ident && !acc_in.found) begin
        acc_nxt.found = 1'b1;
        idx_nxt       = IdxW'(IDX);
      end
      if (match && (!acc_in.hit || (ent_r.len > acc_in.plen))) begin
        acc_nxt.hit   = 1'b1;
        acc_nxt.plen  = ent_r.len;
        acc_nxt.oport = ent_r.port;
      end
    end
  end

  // search word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      idx_r <= idx_nxt;
    end
  end

  // route storage: append at the fill point, or pull from the upper neighbor
  always_ff @(posedge clk) begin
    priority if (upd.wr && (cnt == CntW'(IDX))) begin
      ent_r <= req;
    end else if (upd.shift && (IdxW'(IDX) >= del_idx) && (IDX < TABLE_DEPTH - 1)) begin
      ent_r <= nbr;
    end else begin
      ent_r <= ent_r;
    end
  end

  assign acc_out = acc_r;
  assign idx_out = idx_r;
  assign ent     = ent_r;

endmodule

>>> hw/rtl/rt_lpm_chk.sv
// ----------------------------------------------------------------------------
// rt_lpm_chk
// Port-level checks for the route table, bound to the top level.
// ----------------------------------------------------------------------------
module rt_lpm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic        out_hit,
  input logic [3:0]  out_port,
  input logic [5:0]  out_prefix_length
);

  // a taken request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // busy ends only with a result word
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result word");

  // a result word never shows while a request is in flight
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // a hit reports ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == rt_lpm_pkg::STAT_OK))
    else $error("hit with non-ok status");

  // no hit leaves port and length at zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> ((out_port == 4'd0) && (out_prefix_length == 6'd0)))
    else $error("port or prefix length set without a hit");

endmodule

bind route_table_longest_prefix_match rt_lpm_chk u_rt_lpm_chk (.*);
